/* sv/assert_macros.svh */
// Assertion macros for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* sv/psue_pkg.sv */
// Package: constants, types and helpers of the particle swarm update engine
package psue_pkg;
	localparam int unsigned PsuParticles  = 64;
	localparam int unsigned PsuDimensions = 16;
	localparam int unsigned WordW  = 32;
	localparam int unsigned CoefW  = 18;
	localparam int unsigned RandW  = 16;
	localparam int unsigned PartW  = 6;
	localparam int unsigned DimW   = 4;
	localparam int unsigned CfgIdxW = 3;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_MOVE    = 2'd1,
		CMD_FITNESS = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_POS_MIN  = 3'd0,
		REG_POS_MAX  = 3'd1,
		REG_INERTIA  = 3'd2,
		REG_COEF_P   = 3'd3,
		REG_COEF_G   = 3'd4,
		REG_MAXIMIZE = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_MV_READ,
		ST_MV_COEF,
		ST_MV_MUL,
		ST_MV_SUM,
		ST_MV_WRITE,
		ST_FIT_CMP,
		ST_FIT_READ,
		ST_FIT_COPY,
		ST_FIT_GLOB,
		ST_DONE
	} state_t;

	// which product the shared multiplier forms
	typedef enum logic [2:0] {
		MUL_A1, MUL_A2, MUL_WV, MUL_P, MUL_G
	} mul_sel_t;

	// floor(x / 2^16) of a signed product, arithmetic shift floors
	function automatic logic signed [51:0] fl16(input logic signed [67:0] x);
		fl16 = 52'(x >>> 16);
	endfunction

	function automatic logic signed [WordW-1:0] worst(input logic maxm);
		worst = maxm ? {1'b1, {(WordW-1){1'b0}}} : {1'b0, {(WordW-1){1'b1}}};
	endfunction

	function automatic logic better(input logic maxm,
		input logic signed [WordW-1:0] a, input logic signed [WordW-1:0] b);
		better = maxm ? (a > b) : (a < b);
	endfunction
endpackage

/* sv/psue_ram.sv */
// Generic single-port-write, one-read RAM with registered read data
module psue_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule

/* sv/particle_swarm_update_engine.sv */
// Load goes from dispatch to done; a move steps through read, coefficient, multiply, sum
// and write; fitness copies the position row when the personal best improves and then
// updates the global best. One item at a time: input ready only while idle with no result
// waiting; one multiplier serves a move's five products in turn; the row copy goes one
// element a cycle. arst_n resets control state, configuration and the global best; the
// element stores hold garbage until loaded and take no clearing pass.
module particle_swarm_update_engine #(
	parameter int unsigned PARTICLES  = psue_pkg::PsuParticles,
	parameter int unsigned DIMENSIONS = psue_pkg::PsuDimensions
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [psue_pkg::PartW-1:0]    particle,
	input  logic [psue_pkg::DimW-1:0]     dim,
	input  logic signed [psue_pkg::WordW-1:0] value,
	input  logic [psue_pkg::RandW-1:0]    rand_a,
	input  logic [psue_pkg::RandW-1:0]    rand_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [psue_pkg::WordW-1:0] position,
	output logic                          improved,
	output logic signed [psue_pkg::WordW-1:0] best_value,
	output logic [psue_pkg::PartW-1:0]    best_particle,
	input  logic                          cfg_we,
	input  logic [psue_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [psue_pkg::WordW-1:0]    cfg_wdata
);
	import psue_pkg::*;

	localparam int unsigned Elems = PARTICLES * DIMENSIONS;
	localparam int unsigned PW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
	localparam int unsigned DW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
	localparam int unsigned EW = PW + DW;
	localparam int unsigned CW = $clog2(DIMENSIONS + 1);

	// configuration
	logic signed [WordW-1:0] pos_min_q, pos_max_q;
	logic [CoefW-1:0] inertia_q, coef_p_q, coef_g_q;
	logic maximize_q;
	logic signed [WordW-1:0] gbest_val_q;
	logic [PartW-1:0] gbest_idx_q;

	// captured item
	cmd_t cmd_q;
	logic [PartW-1:0] part_q;
	logic [DimW-1:0] dim_q;
	logic signed [WordW-1:0] val_q;
	logic [RandW-1:0] ra_q, rb_q;
	logic oob_q;

	state_t state_q, state_d;
	logic [2:0] step_q;
	logic [CW-1:0] cnt_q;

	// move datapath
	logic signed [WordW-1:0] x_q, v_q, p_q, g_q, pbv_q;
	logic [CoefW-1:0] a1_q, a2_q;
	logic signed [51:0] acc_q;
	logic signed [67:0] prod_s1;
	logic signed [WordW-1:0] newv_q;

	// outputs
	logic signed [WordW-1:0] pos_out_q;
	logic imp_q;
	logic out_valid_q;

	// memories
	logic pos_we, vel_we, pb_we, pbv_we;
	logic [EW-1:0] pos_waddr, pb_waddr, pos_raddr, pb_raddr, vel_addr;
	logic [WordW-1:0] pos_wdata, vel_wdata, pb_wdata, pbv_wdata;
	logic [WordW-1:0] pos_rdata, vel_rdata, pb_rdata, pbv_rdata;
	logic [PW-1:0] part_i, gidx_i;
	logic [DW-1:0] dim_i, cnt_i;
	logic [EW-1:0] elem_i, gelem_i, row_i;

	assign part_i  = PW'(part_q);
	assign gidx_i  = (32'(gbest_idx_q) < PARTICLES) ? PW'(gbest_idx_q) : '0;
	assign dim_i   = DW'(dim_q);
	assign cnt_i   = DW'(cnt_q);
	assign elem_i  = EW'(32'(part_i) * DIMENSIONS + 32'(dim_i));
	assign gelem_i = EW'(32'(gidx_i) * DIMENSIONS + 32'(dim_i));
	assign row_i   = EW'(32'(part_i) * DIMENSIONS + 32'(cnt_i));

	psue_ram #(.Width(WordW), .Depth(Elems)) u_pos (
		.clk, .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(pos_raddr), .rdata(pos_rdata));
	psue_ram #(.Width(WordW), .Depth(Elems)) u_vel (
		.clk, .we(vel_we), .waddr(vel_addr), .wdata(vel_wdata),
		.raddr(vel_addr), .rdata(vel_rdata));
	psue_ram #(.Width(WordW), .Depth(Elems)) u_pb (
		.clk, .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
		.raddr(pb_raddr), .rdata(pb_rdata));
	psue_ram #(.Width(WordW), .Depth(PARTICLES)) u_pbv (
		.clk, .we(pbv_we), .waddr(part_i), .wdata(pbv_wdata),
		.raddr(part_i), .rdata(pbv_rdata));

	assign in_ready   = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid  = out_valid_q;
	assign position   = pos_out_q;
	assign improved   = imp_q;
	assign best_value = gbest_val_q;
	assign best_particle = gbest_idx_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid && in_ready) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				if (oob_q) state_d = ST_DONE;
				else if (cmd_q == CMD_LOAD) state_d = ST_DONE;
				else if (cmd_q == CMD_MOVE) state_d = ST_MV_READ;
				else if (cmd_q == CMD_FITNESS) state_d = ST_FIT_CMP;
				else state_d = ST_DONE;
			end
			ST_MV_READ: state_d = ST_MV_COEF;
			ST_MV_COEF: if (step_q == 3'd1) state_d = ST_MV_MUL;
			ST_MV_MUL: if (step_q == 3'd2) state_d = ST_MV_SUM;
			ST_MV_SUM: state_d = ST_MV_WRITE;
			ST_MV_WRITE: state_d = ST_DONE;
			ST_FIT_CMP: state_d = better(maximize_q, val_q, pbv_rdata) ?
				ST_FIT_READ : ST_FIT_GLOB;
			ST_FIT_READ: state_d = ST_FIT_COPY;
			ST_FIT_COPY: if (32'(cnt_q) == DIMENSIONS) state_d = ST_FIT_GLOB;
			ST_FIT_GLOB: state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		pos_we = 1'b0; vel_we = 1'b0; pb_we = 1'b0; pbv_we = 1'b0;
		pos_waddr = elem_i; pb_waddr = elem_i; vel_addr = elem_i;
		pos_raddr = elem_i; pb_raddr = elem_i;
		pos_wdata = val_q; vel_wdata = '0; pb_wdata = val_q;
		pbv_wdata = worst(maximize_q);
		case (state_q)
			ST_DISPATCH: begin
				if (!oob_q && cmd_q == CMD_LOAD) begin
					pos_we = 1'b1; vel_we = 1'b1; pb_we = 1'b1; pbv_we = 1'b1;
				end
			end
			ST_MV_READ: pb_raddr = gelem_i;
			ST_FIT_CMP: begin
				pos_raddr = row_i;
				if (better(maximize_q, val_q, pbv_rdata)) begin
					pbv_we = 1'b1;
					pbv_wdata = val_q;
				end
			end
			ST_FIT_READ: pos_raddr = row_i;
			ST_FIT_COPY: begin
				pos_raddr = row_i;
				pb_we = 1'b1;
				pb_waddr = EW'(32'(part_i) * DIMENSIONS + 32'(cnt_q) - 1);
				pb_wdata = pos_rdata;
			end
			ST_MV_WRITE: begin
				pos_we = 1'b1; vel_we = 1'b1;
				pos_wdata = tlim; vel_wdata = newv_q;
			end
			default: ;
		endcase
	end

	// shared multiplier operand select, registered product
	mul_sel_t msel;
	logic signed [35:0] mop_a;
	logic signed [32:0] mop_b;
	always_comb begin
		msel = MUL_A1;
		case (state_q)
			ST_MV_COEF: msel = (step_q == 3'd0) ? MUL_A1 : MUL_A2;
			ST_MV_MUL: begin
				case (step_q)
					3'd0: msel = MUL_WV;
					3'd1: msel = MUL_P;
					default: msel = MUL_G;
				endcase
			end
			default: msel = MUL_A1;
		endcase
		case (msel)
			MUL_A1: begin mop_a = 36'(coef_p_q); mop_b = 33'(ra_q); end
			MUL_A2: begin mop_a = 36'(coef_g_q); mop_b = 33'(rb_q); end
			MUL_WV: begin mop_a = 36'(inertia_q); mop_b = 33'(v_q); end
			MUL_P:  begin mop_a = 36'(a1_q); mop_b = 33'(p_q) - 33'(x_q); end
			MUL_G:  begin mop_a = 36'(a2_q); mop_b = 33'(g_q) - 33'(x_q); end
			default: begin mop_a = '0; mop_b = '0; end
		endcase
	end

	logic signed [52:0] vsum;
	logic signed [WordW:0] tsum;
	logic signed [WordW-1:0] vsat, tlim;
	always_comb begin
		vsum = 53'(acc_q) + 53'(fl16(prod_s1));
		if (vsum > 53'sh7FFFFFFF) vsat = {1'b0, {(WordW-1){1'b1}}};
		else if (vsum < -53'sh80000000) vsat = {1'b1, {(WordW-1){1'b0}}};
		else vsat = vsum[WordW-1:0];
		tsum = 33'(x_q) + 33'(newv_q);
		tlim = tsum[WordW-1:0];
		if (tsum > 33'(pos_max_q)) tlim = pos_max_q;
		if ((tsum > 33'(pos_max_q) ? 33'(pos_max_q) : tsum) < 33'(pos_min_q))
			tlim = pos_min_q;
	end

	// state, configuration and global best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			pos_min_q <= -32'sd655360;
			pos_max_q <= 32'sd655360;
			inertia_q <= 18'd45875;
			coef_p_q <= 18'd98304;
			coef_g_q <= 18'd98304;
			maximize_q <= 1'b0;
			gbest_val_q <= worst(1'b0);
			gbest_idx_q <= '0;
		end else begin
			state_q <= state_d;
			// hold the result until taken
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == ST_DONE && state_d == ST_IDLE) out_valid_q <= 1'b1;
			// step counter of the multiplier sequence
			if (state_q != state_d) step_q <= '0;
			else step_q <= step_q + 3'd1;
			// row copy counter
			if (state_q == ST_FIT_CMP) cnt_q <= '0;
			else if (state_q == ST_FIT_READ || state_q == ST_FIT_COPY) cnt_q <= cnt_q + CW'(1);
			if (state_q == ST_FIT_GLOB && better(maximize_q, pbv_q, gbest_val_q)) begin
				gbest_val_q <= pbv_q;
				gbest_idx_q <= part_q;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_POS_MIN:  pos_min_q <= cfg_wdata;
					REG_POS_MAX:  pos_max_q <= cfg_wdata;
					REG_INERTIA:  inertia_q <= cfg_wdata[CoefW-1:0];
					REG_COEF_P:   coef_p_q <= cfg_wdata[CoefW-1:0];
					REG_COEF_G:   coef_g_q <= cfg_wdata[CoefW-1:0];
					REG_MAXIMIZE: begin
						maximize_q <= cfg_wdata[0];
						gbest_val_q <= worst(cfg_wdata[0]);
						gbest_idx_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= 68'(mop_a) * 68'(mop_b);
		if (in_valid && in_ready) begin
			cmd_q <= cmd_t'(command);
			part_q <= particle;
			dim_q <= dim;
			val_q <= value;
			ra_q <= rand_a;
			rb_q <= rand_b;
			oob_q <= (32'(particle) >= PARTICLES) ||
				(32'(dim) >= DIMENSIONS && command != CMD_FITNESS);
		end
		case (state_q)
			ST_DISPATCH: begin
				pos_out_q <= (!oob_q && cmd_q == CMD_LOAD) ? val_q : '0;
				imp_q <= 1'b0;
			end
			ST_MV_READ: begin
				x_q <= pos_rdata; v_q <= vel_rdata; p_q <= pb_rdata;
			end
			ST_MV_COEF: begin
				if (step_q == 3'd0) g_q <= pb_rdata;
				if (step_q == 3'd1) a1_q <= prod_s1[CoefW+15:16];
			end
			ST_MV_MUL: begin
				if (step_q == 3'd0) a2_q <= prod_s1[CoefW+15:16];
				if (step_q == 3'd1) acc_q <= fl16(prod_s1);
				if (step_q == 3'd2) acc_q <= 52'(acc_q) + fl16(prod_s1);
			end
			ST_MV_SUM: newv_q <= vsat;
			ST_MV_WRITE: pos_out_q <= tlim;
			ST_FIT_CMP: begin
				// take the stored personal best value, or the new one when it wins
				pbv_q <= better(maximize_q, val_q, pbv_rdata) ? val_q : pbv_rdata;
				if (better(maximize_q, val_q, pbv_rdata)) imp_q <= 1'b1;
			end
			default: ;
		endcase
	end
endmodule

/* sv/psue_checker.sv */
// Port-level checker for the particle swarm update engine, with its bind
`include "assert_macros.svh"
module psue_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       improved,
	input logic [31:0] position
);
	import psue_pkg::*;

	`CHK_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready after accept")
	`CHK_IMPL(a_no_accept_with_result, clk, arst_n, out_valid, !in_ready, "ready with result pending")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(position), "result dropped")
	`CHK_IMPL(a_imp_pos_zero, clk, arst_n, out_valid && improved, position == 32'd0, "improved with position")
endmodule

bind particle_swarm_update_engine psue_checker u_psue_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.improved(improved), .position(position));

/* tb/particle_swarm_update_engine_checker.sv */
// Checker for the particle swarm update engine: predicts each result and compares it
`timescale 1ns / 1ps

module particle_swarm_update_engine_checker
	import psue_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [1:0]               command,
	input  logic [PartW-1:0]         particle,
	input  logic [DimW-1:0]          dim,
	input  logic signed [WordW-1:0]  value,
	input  logic [RandW-1:0]         rand_a,
	input  logic [RandW-1:0]         rand_b,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [WordW-1:0]  position,
	input  logic                     improved,
	input  logic signed [WordW-1:0]  best_value,
	input  logic [PartW-1:0]         best_particle,
	input  logic                     cfg_we,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [WordW-1:0]         cfg_wdata,
	output int                       fail_count,
	output int                       pending
);
	typedef struct {
		logic signed [WordW-1:0] position;
		logic                    improved;
		logic signed [WordW-1:0] best_value;
		logic [PartW-1:0]        best_particle;
	} swarm_result_t;

	localparam int Elems = PsuParticles * PsuDimensions;

	// swarm state as the block should hold it
	logic signed [WordW-1:0] pos_mem [Elems];
	logic signed [WordW-1:0] vel_mem [Elems];
	logic signed [WordW-1:0] pbest_mem [Elems];
	logic signed [WordW-1:0] pbest_val [PsuParticles];
	logic signed [WordW-1:0] gbest_val;
	logic [PartW-1:0]        gbest_idx;

	// configuration copy
	logic signed [WordW-1:0] lim_lo, lim_hi;
	logic [CoefW-1:0]        w_inertia, c_pers, c_glob;
	logic                    maxim;

	swarm_result_t expected_results[$];

	assign pending = expected_results.size();

	function automatic logic signed [WordW-1:0] mode_worst(input logic m);
		return m ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

	function automatic logic beats_best(input logic m, input logic signed [WordW-1:0] a,
		input logic signed [WordW-1:0] b);
		return m ? (a > b) : (a < b);
	endfunction

	// floor of a signed value divided by 2^16
	function automatic longint floor_q16(input longint x);
		return x >>> 16;
	endfunction

	// apply one beat to the swarm state and form its result
	task automatic swarm_step(input cmd_t c, input int p, input int d,
		input logic signed [WordW-1:0] v, input logic [RandW-1:0] ra,
		input logic [RandW-1:0] rb, output swarm_result_t r);
		int e, ge, base;
		longint x, a1, a2, nv, t;
		logic signed [WordW-1:0] vs;
		e = p * PsuDimensions + d;
		r.position = '0;
		r.improved = 1'b0;
		case (c)
			CMD_LOAD: begin
				pos_mem[e] = v;
				pbest_mem[e] = v;
				vel_mem[e] = '0;
				pbest_val[p] = mode_worst(maxim);
				r.position = v;
			end
			CMD_MOVE: begin
				ge = gbest_idx * PsuDimensions + d;
				x = pos_mem[e];
				a1 = (longint'(c_pers) * longint'(ra)) >>> 16;
				a2 = (longint'(c_glob) * longint'(rb)) >>> 16;
				nv = floor_q16(longint'(w_inertia) * longint'(vel_mem[e]))
					+ floor_q16(a1 * (longint'(pbest_mem[e]) - x))
					+ floor_q16(a2 * (longint'(pbest_mem[ge]) - x));
				if (nv > 64'sd2147483647) vs = 32'sh7fff_ffff;
				else if (nv < -64'sd2147483648) vs = 32'sh8000_0000;
				else vs = nv[WordW-1:0];
				vel_mem[e] = vs;
				t = x + longint'(vs);
				// upper limit first so a crossed lower limit wins
				if (t > longint'(lim_hi)) t = lim_hi;
				if (t < longint'(lim_lo)) t = lim_lo;
				pos_mem[e] = t[WordW-1:0];
				r.position = t[WordW-1:0];
			end
			CMD_FITNESS: begin
				if (beats_best(maxim, v, pbest_val[p])) begin
					base = p * PsuDimensions;
					for (int i = 0; i < PsuDimensions; i++)
						pbest_mem[base + i] = pos_mem[base + i];
					pbest_val[p] = v;
					r.improved = 1'b1;
				end
				if (beats_best(maxim, pbest_val[p], gbest_val)) begin
					gbest_val = pbest_val[p];
					gbest_idx = p[PartW-1:0];
				end
			end
			default: ;
		endcase
		r.best_value = gbest_val;
		r.best_particle = gbest_idx;
	endtask

	always @(posedge clk or negedge arst_n) begin
		swarm_result_t r, exp_r;
		if (!arst_n) begin
			lim_lo = -32'sd655360;
			lim_hi = 32'sd655360;
			w_inertia = 18'd45875;
			c_pers = 18'd98304;
			c_glob = 18'd98304;
			maxim = 1'b0;
			gbest_val = mode_worst(1'b0);
			gbest_idx = '0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			// compare the result beat against the oldest expectation
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with nothing expected: pos %0d imp %0d best %0d/%0d",
						$time, position, improved, best_value, best_particle);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (position !== exp_r.position) begin
						$display("%0t: position expected %0d actual %0d", $time,
							exp_r.position, position);
						fail_count++;
					end
					if (improved !== exp_r.improved) begin
						$display("%0t: improved expected %0d actual %0d", $time,
							exp_r.improved, improved);
						fail_count++;
					end
					if (best_value !== exp_r.best_value) begin
						$display("%0t: best_value expected %0d actual %0d", $time,
							exp_r.best_value, best_value);
						fail_count++;
					end
					if (best_particle !== exp_r.best_particle) begin
						$display("%0t: best_particle expected %0d actual %0d", $time,
							exp_r.best_particle, best_particle);
						fail_count++;
					end
				end
			end
			// predict each accepted input beat
			if (in_valid && in_ready) begin
				swarm_step(cmd_t'(command), int'(particle), int'(dim), value, rand_a,
					rand_b, r);
				expected_results = {expected_results, r};
			end
			// track register writes
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_POS_MIN: lim_lo = cfg_wdata;
					REG_POS_MAX: lim_hi = cfg_wdata;
					REG_INERTIA: w_inertia = cfg_wdata[CoefW-1:0];
					REG_COEF_P: c_pers = cfg_wdata[CoefW-1:0];
					REG_COEF_G: c_glob = cfg_wdata[CoefW-1:0];
					REG_MAXIMIZE: begin
						maxim = cfg_wdata[0];
						gbest_val = mode_worst(cfg_wdata[0]);
						gbest_idx = '0;
					end
					default: ;
				endcase
			end
		end
	end
endmodule

/* tb/particle_swarm_update_engine_tb.sv */
// Testbench top for the particle swarm update engine: stimulus, pacing and verdict
`timescale 1ns / 1ps

module particle_swarm_update_engine_tb;
	import psue_pkg::*;

	localparam int StallLimit = 5000;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              command;
	logic [PartW-1:0]        particle;
	logic [DimW-1:0]         dim;
	logic signed [WordW-1:0] value;
	logic [RandW-1:0]        rand_a, rand_b;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [WordW-1:0] position;
	logic                    improved;
	logic signed [WordW-1:0] best_value;
	logic [PartW-1:0]        best_particle;
	logic                    cfg_we;
	logic [CfgIdxW-1:0]      cfg_index;
	logic [WordW-1:0]        cfg_wdata;
	int                      fail_count;
	int                      pending;

	// elements written since reset; moves and fitness beats only touch these
	bit loaded [PsuParticles][PsuDimensions];
	int burst_left;
	int idle_count;

	particle_swarm_update_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .particle(particle), .dim(dim), .value(value),
		.rand_a(rand_a), .rand_b(rand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.position(position), .improved(improved),
		.best_value(best_value), .best_particle(best_particle),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	particle_swarm_update_engine_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .particle(particle), .dim(dim), .value(value),
		.rand_a(rand_a), .rand_b(rand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.position(position), .improved(improved),
		.best_value(best_value), .best_particle(best_particle),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver stall pattern: ready, random or mostly stalled per window
	initial begin
		int win, mode;
		out_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			win = $urandom_range(8, 80);
			repeat (win) begin
				@(negedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	initial begin
		idle_count = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_count = 0;
			else
				idle_count++;
			if (idle_count >= StallLimit) begin
				$display("particle_swarm_update_engine: mismatch");
				$finish;
			end
		end
	end

	function automatic bit row_loaded(input int p);
		for (int i = 0; i < PsuDimensions; i++)
			if (!loaded[p][i]) return 1'b0;
		return 1'b1;
	endfunction

	// drive one beat and hold it until accepted, then pace the sender
	task automatic send_beat(input cmd_t c, input int p, input int d,
		input logic [WordW-1:0] v, input logic [RandW-1:0] ra, input logic [RandW-1:0] rb);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		command <= c;
		particle <= p[PartW-1:0];
		dim <= d[DimW-1:0];
		value <= v;
		rand_a <= ra;
		rand_b <= rb;
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		if (c == CMD_LOAD) loaded[p][d] = 1'b1;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(0, 24);
		end
	endtask

	// hold the sender until every expected result has arrived
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [WordW-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input logic [WordW-1:0] lo, input logic [WordW-1:0] hi,
		input logic [WordW-1:0] w, input logic [WordW-1:0] c1,
		input logic [WordW-1:0] c2, input logic [WordW-1:0] mx);
		write_reg(REG_POS_MIN, lo);
		write_reg(REG_POS_MAX, hi);
		write_reg(REG_INERTIA, w);
		write_reg(REG_COEF_P, c1);
		write_reg(REG_COEF_G, c2);
		write_reg(REG_MAXIMIZE, mx);
	endtask

	task automatic load_row(input int p);
		for (int d = 0; d < PsuDimensions; d++)
			send_beat(CMD_LOAD, p, d, $signed($urandom_range(0, 40 << 16)) - (20 << 16),
				$urandom, $urandom);
	endtask

	function automatic logic [WordW-1:0] rand_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
		endcase
	endfunction

	function automatic logic [RandW-1:0] rand_frac();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// one random beat; moves and fitness only on written elements
	task automatic random_beat();
		int sel, p, d, tries;
		sel = $urandom_range(0, 99);
		p = ($urandom_range(0, 1)) ? $urandom_range(0, 7) : $urandom_range(0, 63);
		d = $urandom_range(0, PsuDimensions - 1);
		if (sel < 6) begin
			load_row($urandom_range(0, 63));
		end else if (sel < 28) begin
			send_beat(CMD_LOAD, p, d, rand_word(), $urandom, $urandom);
		end else if (sel < 65) begin
			tries = 0;
			while (!loaded[p][d] && tries < 8) begin
				p = $urandom_range(0, 7);
				d = $urandom_range(0, PsuDimensions - 1);
				tries++;
			end
			if (!loaded[p][d]) p = 0;
			send_beat(CMD_MOVE, p, d, $urandom, rand_frac(), rand_frac());
		end else if (sel < 90) begin
			tries = 0;
			while (!row_loaded(p) && tries < 8) begin
				p = $urandom_range(0, 63);
				tries++;
			end
			if (!row_loaded(p)) p = 0;
			send_beat(CMD_FITNESS, p, d, rand_word(), $urandom, $urandom);
		end else begin
			send_beat(CMD_NONE, $urandom_range(0, 63), d, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_NONE;
		particle = '0;
		dim = '0;
		value = '0;
		rand_a = '0;
		rand_b = '0;
		cfg_we = 1'b0;
		cfg_index = REG_POS_MIN;
		cfg_wdata = '0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// seed full rows so every move and fitness beat reads written elements
		for (int p = 0; p < 4; p++) load_row(p);

		// directed: extremes, every command, strict compare, clamp
		send_beat(CMD_LOAD, 63, 15, 32'h7fff_ffff, '0, '0);
		send_beat(CMD_LOAD, 63, 0, 32'h8000_0000, '1, '1);
		send_beat(CMD_MOVE, 63, 15, '0, '1, '1);
		send_beat(CMD_MOVE, 63, 0, '0, '1, '1);
		send_beat(CMD_MOVE, 1, 5, '0, '0, '0);
		send_beat(CMD_MOVE, 2, 7, '0, '1, '1);
		send_beat(CMD_FITNESS, 1, 0, 32'sd1000, '0, '0);
		send_beat(CMD_FITNESS, 1, 0, 32'sd1000, '0, '0);
		send_beat(CMD_FITNESS, 2, 0, 32'sd999, '0, '0);
		send_beat(CMD_FITNESS, 3, 0, 32'h7fff_ffff, '0, '0);
		send_beat(CMD_FITNESS, 3, 0, 32'h8000_0000, '0, '0);
		send_beat(CMD_MOVE, 1, 3, '0, '1, '1);
		send_beat(CMD_MOVE, 0, 9, '0, 16'h8000, 16'h8000);
		send_beat(CMD_NONE, 63, 15, 32'hffff_ffff, '1, '1);
		send_beat(CMD_NONE, 0, 0, '0, '0, '0);

		// phases over register settings, extremes among them
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: write_all(-32'sd655360, 32'sd655360, 45875, 98304, 98304, 0);
				1: write_all(32'h8000_0000, 32'h7fff_ffff, 18'h3ffff, 18'h3ffff, 18'h3ffff, 1);
				2: write_all(32'sd1000, -32'sd1000, 0, 0, 0, 0);
				default: write_all(-($urandom_range(1, 100) << 16), $urandom_range(1, 100) << 16,
					$urandom_range(0, 18'h3ffff), $urandom_range(0, 18'h3ffff),
					$urandom_range(0, 18'h3ffff), 1);
			endcase
			for (int i = 0; i < 170; i++) begin
				random_beat();
				if (ph == 1 && i == 85) drain();
			end
		end

		drain();
		if (fail_count == 0)
			$display("particle_swarm_update_engine: match");
		else
			$display("particle_swarm_update_engine: mismatch");
		$finish;
	end
endmodule
